>>> rtl/hashed_integer_set_top_defines.svh
// ----------------------------------------------------------------------------
// Hashed integer set - assertion macros
// Shared concurrent assertion forms, clocked on clock, muted during reset.
// ----------------------------------------------------------------------------
`ifndef HASHED_INTEGER_SET_TOP_DEFINES_SVH
`define HASHED_INTEGER_SET_TOP_DEFINES_SVH

// same-cycle implication
`define HIS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HIS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/his_pkg.sv
// ----------------------------------------------------------------------------
// Hashed integer set - package
// Field widths and command codes shared by the channels and the datapath.
// ----------------------------------------------------------------------------
package his_pkg;

   localparam int KEY_W   = 32;
   localparam int CMD_W   = 2;
   localparam int COUNT_W = 9;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

endpackage

>>> rtl/his_channels.sv
// ----------------------------------------------------------------------------
// Hashed integer set - channel interfaces
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface his_req_if;
   import his_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic signed [KEY_W-1:0] key;

   modport source (output valid, output command, output key, input ready);
   modport sink   (input valid, input command, input key, output ready);
endinterface

interface his_rsp_if;
   import his_pkg::*;

   logic               valid;
   logic               ready;
   logic               was_present;
   logic               bucket_full;
   logic [COUNT_W-1:0] element_count;

   modport source (output valid, output was_present, output bucket_full,
                   output element_count, input ready);
   modport sink   (input valid, input was_present, input bucket_full,
                   input element_count, output ready);
endinterface

>>> rtl/his_bucket_mod.sv
// ----------------------------------------------------------------------------
// Hashed integer set - bucket reduction
// Sign-extended key modulo BUCKETS on one shared 32x32 multiplier:
// reciprocal quotient estimate, remainder, two compare-subtract steps.
// ----------------------------------------------------------------------------
module his_bucket_mod #(
   parameter int BUCKETS = 101
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [his_pkg::KEY_W-1:0]   key,
   output logic                        done,
   output logic [$clog2(BUCKETS)-1:0]  bucket
);
   import his_pkg::*;

   localparam int RW = $clog2(BUCKETS);
   localparam int PW = 2 * KEY_W;
   // remainder before correction is below 3*BUCKETS
   localparam int FW = RW + 2;

   localparam logic [PW-1:0] KEY_SPAN = PW'(1) << KEY_W;
   localparam logic [PW-1:0] BKT_WIDE = PW'(BUCKETS);
   // floor(2^32 / BUCKETS); the quotient it gives is low by at most one
   localparam logic [KEY_W-1:0] RECIP = KEY_W'(KEY_SPAN / BKT_WIDE);
   // all-ones upper half of a negative key, already reduced
   localparam logic [KEY_W-1:0] HI_REM =
      KEY_W'((((KEY_SPAN - PW'(1)) % BKT_WIDE) * (KEY_SPAN % BKT_WIDE)) % BKT_WIDE);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_QUOT,   // quotient estimate: key * RECIP, upper half
      PH_PROD,   // key - quotient * BUCKETS, upper half folded in
      PH_FIX1,
      PH_FIX2
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic             done_ff,  done_in;
   logic             neg_ff,   neg_in;
   logic [KEY_W-1:0] lo_ff,    lo_in;
   logic [KEY_W-1:0] quot_ff,  quot_in;
   logic [FW-1:0]    rem_ff,   rem_in;

   // shared multiplier and its neighbors
   logic [KEY_W-1:0] mul_a;
   logic [KEY_W-1:0] mul_b;
   logic [PW-1:0]    product;
   logic [KEY_W-1:0] partial;
   logic [FW-1:0]    rem_sub;

   always_comb begin
      mul_a = lo_ff;
      mul_b = RECIP;
      if (phase_ff == PH_PROD) begin
         mul_a = quot_ff;
         mul_b = KEY_W'(BUCKETS);
      end
      product = PW'(mul_a) * PW'(mul_b);
      partial = lo_ff - product[KEY_W-1:0] + (neg_ff ? HI_REM : '0);
      rem_sub = (rem_ff >= FW'(BUCKETS)) ? rem_ff - FW'(BUCKETS) : rem_ff;

      phase_in = phase_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      lo_in    = lo_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               lo_in    = key;
               neg_in   = key[KEY_W-1];
               phase_in = PH_QUOT;
            end
         end
         PH_QUOT: begin
            quot_in  = product[PW-1:KEY_W];
            phase_in = PH_PROD;
         end
         PH_PROD: begin
            rem_in   = partial[FW-1:0];
            phase_in = PH_FIX1;
         end
         PH_FIX1: begin
            rem_in   = rem_sub;
            phase_in = PH_FIX2;
         end
         PH_FIX2: begin
            rem_in   = rem_sub;
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      neg_ff  <= neg_in;
      lo_ff   <= lo_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done   = done_ff;
   assign bucket = rem_ff[RW-1:0];

endmodule

>>> rtl/hashed_integer_set_top.sv
// ----------------------------------------------------------------------------
// Hashed integer set - top level
// Set of signed 32-bit keys in BUCKETS rows of WAYS slots; insert, look up
// and remove, one response per request.
// ----------------------------------------------------------------------------
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   command[1:0], key[31:0] signed
//   rsp_chan  out  valid/ready   was_present, bucket_full, element_count[8:0]
//
// A request passes through the bucket unit (reciprocal quotient, remainder,
// two correction steps), the row read, then compare and write-back in the
// same cycle. The shared multiplier sequence in the bucket unit is the
// longest part of that path.
// After reset a clearing pass writes every row; no request is taken
// meanwhile.
// The response sits in an output register; the write-back cycle waits until
// that register is free, so a stalled response holds back the next request.
// ----------------------------------------------------------------------------
`include "hashed_integer_set_top_defines.svh"

module hashed_integer_set_top #(
   parameter int BUCKETS = 101,
   parameter int WAYS    = 4
) (
   input  logic      clock,
   input  logic      reset,
   his_req_if.sink   req_chan,
   his_rsp_if.source rsp_chan
);
   import his_pkg::*;

   localparam int RW    = $clog2(BUCKETS);
   localparam int SLOTS = BUCKETS * WAYS;
   localparam int CNT_W = $clog2(SLOTS + 1);

   // one memory row per bucket: slot valid marks and slot keys
   typedef struct packed {
      logic [WAYS-1:0]             vld;
      logic [WAYS-1:0][KEY_W-1:0]  keys;
   } row_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_UPDATE
   } state_type;

   state_type          state_ff, state_in;
   logic [RW-1:0]      clr_ff, clr_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [RW-1:0]      addr_ff, addr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               was_present_ff, was_present_in;
   logic               bucket_full_ff, bucket_full_in;
   logic [COUNT_W-1:0] elem_ff, elem_in;

   // row memory
   row_type row_mem [BUCKETS];
   row_type rd_row_ff;
   logic    mem_we;
   logic    mem_re;
   logic [RW-1:0] mem_waddr;
   row_type mem_wdata;

   // bucket reduction
   logic          hash_start;
   logic          hash_done;
   logic [RW-1:0] hash_bucket;

   // row compare
   logic [WAYS-1:0] match;
   logic [WAYS-1:0] hit_oh;
   logic [WAYS-1:0] free_oh;
   logic            hit;
   logic            free_any;
   logic            do_insert;
   logic            do_remove;
   logic            out_free;
   logic            req_fire;
   row_type         new_row;

   his_bucket_mod #(
      .BUCKETS (BUCKETS)
   ) u_bucket_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key    (key_in),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // compare the key against every way; lowest matching and lowest free slot
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         match[w] = rd_row_ff.vld[w] && (rd_row_ff.keys[w] == key_ff);
      end
      hit_oh   = match & (~match + WAYS'(1));
      free_oh  = ~rd_row_ff.vld & (rd_row_ff.vld + WAYS'(1));
      hit      = |match;
      free_any = |free_oh;

      do_insert = 1'b0;
      do_remove = 1'b0;
      unique case (cmd_ff)
         CMD_INSERT: do_insert = !hit && free_any;
         CMD_REMOVE: do_remove = hit;
         default:    ;  // look up, and the unused code
      endcase

      new_row = rd_row_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (do_insert && free_oh[w]) begin
            new_row.vld[w]  = 1'b1;
            new_row.keys[w] = key_ff;
         end
         if (do_remove && hit_oh[w]) begin
            new_row.vld[w] = 1'b0;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      addr_in        = addr_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      was_present_in = was_present_ff;
      bucket_full_in = bucket_full_ff;
      elem_in        = elem_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_waddr      = addr_ff;
      mem_wdata      = new_row;
      hash_start     = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + RW'(1);
            if (clr_ff == RW'(BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd_in     = req_chan.command;
               key_in     = $unsigned(req_chan.key);
               hash_start = 1'b1;
               state_in   = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               mem_re   = 1'b1;
               addr_in  = hash_bucket;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (out_free) begin
               mem_we = 1'b1;
               if (do_insert) begin
                  count_in = count_ff + CNT_W'(1);
               end else if (do_remove) begin
                  count_in = count_ff - CNT_W'(1);
               end
               rsp_valid_in   = 1'b1;
               was_present_in = hit;
               bucket_full_in = (cmd_ff == CMD_INSERT) && !hit && !free_any;
               elem_in        = COUNT_W'(count_in);
               state_in       = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      key_ff         <= key_in;
      addr_ff        <= addr_in;
      was_present_ff <= was_present_in;
      bucket_full_ff <= bucket_full_in;
      elem_ff        <= elem_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_row_ff <= row_mem[hash_bucket];
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.was_present   = was_present_ff;
   assign rsp_chan.bucket_full   = bucket_full_ff;
   assign rsp_chan.element_count = elem_ff;

   `HIS_ASSERT_NXT(a_busy_after_accept, req_fire, !req_chan.ready, "ready after accept")
   `HIS_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(SLOTS), "count above slots")
   `HIS_ASSERT_IMP(a_bucket_range, hash_done, hash_bucket <= RW'(BUCKETS - 1), "bucket range")
   `HIS_ASSERT_IMP(a_full_absent, rsp_valid_ff && bucket_full_ff, !was_present_ff, "full on hit")
   `HIS_ASSERT_NXT(a_count_hold, state_ff != S_UPDATE, $stable(count_ff), "count moved")

endmodule

>>> dv/hashed_integer_set_top_tb.sv
// ----------------------------------------------------------------------------
// Hashed integer set - testbench
// Drives insert, lookup and remove requests into the set, keeps its own
// bucket/slot image to predict each response, and checks every response
// field by field. Covers key extremes, bucket overflow, a full fill and
// drain of the table, clustered random traffic, response back-pressure and
// a final stretch at full rate.
// ----------------------------------------------------------------------------
module hashed_integer_set_top_tb;
   import his_pkg::*;

   localparam int BUCKETS = 101;
   localparam int WAYS    = 4;
   localparam int SLOTS   = BUCKETS * WAYS;

   // Spare command code; the block treats it as a lookup.
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   // Quiet-cycle limit. Slowest legitimate gap is the long response hold-off
   // (HOLD_OFF_CYCLES) plus one request's passage through the block; the
   // clearing pass after reset is the other long wait. Limit is several times the worst of these.
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int QUIET_LIMIT     = 1500;
   // Drain time after the last response: one full request latency plus margin.
   localparam int DRAIN_CYCLES    = 40;

   typedef struct packed {
      logic               was_present;
      logic               bucket_full;
      logic [COUNT_W-1:0] element_count;
   } set_outcome_type;

   logic clock = 1'b0;
   logic reset;

   his_req_if req_bus ();
   his_rsp_if rsp_bus ();

   hashed_integer_set_top #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   // 2-unit clock period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Set image used for prediction
   // ------------------------------------------------------------------------
   logic [KEY_W-1:0] image_key  [SLOTS];
   bit               image_used [SLOTS];
   int unsigned      image_count;

   set_outcome_type pending_outcomes[$];

   int error_count;
   int request_count;
   int refused_count;
   int hit_count;
   int peak_count;

   // Idling controls for the sender and the receiver.
   bit sender_idling;
   bit receiver_idling;
   int hold_off_request;   // set by a test, picked up by the receiver

   // Bucket = key sign-extended to 64 bits, unsigned, modulo BUCKETS.
   // Insert takes the lowest free way; remove clears the first matching way.
   function automatic set_outcome_type predict_outcome(input logic [CMD_W-1:0] cmd,
                                                       input logic [KEY_W-1:0] key);
      logic [63:0]     wide;
      int              base;
      int              hit;
      int              free_slot;
      int              w;
      set_outcome_type outcome;
      wide      = {{32{key[KEY_W-1]}}, key};
      base      = int'(wide % 64'(BUCKETS)) * WAYS;
      hit       = -1;
      free_slot = -1;
      outcome   = '0;
      for (w = 0; w < WAYS; w++) begin
         if (image_used[base + w]) begin
            if (hit < 0 && image_key[base + w] == key) hit = base + w;
         end else if (free_slot < 0) begin
            free_slot = base + w;
         end
      end
      if (cmd == CMD_INSERT) begin
         if (hit < 0) begin
            if (free_slot >= 0) begin
               image_key[free_slot]  = key;
               image_used[free_slot] = 1'b1;
               image_count++;
            end else begin
               outcome.bucket_full = 1'b1;
            end
         end
      end else if (cmd == CMD_REMOVE) begin
         if (hit >= 0) begin
            image_used[hit] = 1'b0;
            image_count--;
         end
      end
      outcome.was_present   = (hit >= 0);
      outcome.element_count = image_count[COUNT_W-1:0];
      return outcome;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: entered and left at a falling edge. Valid stays high
   // from one request to the next unless an idle burst is inserted.
   // ------------------------------------------------------------------------
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
      set_outcome_type outcome;
      if (sender_idling && $urandom_range(0, 5) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_bus.valid   = 1'b1;
      req_bus.command = cmd;
      req_bus.key     = key;
      do @(posedge clock); while (!req_bus.ready);
      // accepted at this edge: predict in acceptance order
      outcome = predict_outcome(cmd, key);
      pending_outcomes.insert(pending_outcomes.size(), outcome);
      request_count++;
      if (outcome.bucket_full) refused_count++;
      if (outcome.was_present) hit_count++;
      if (image_count > peak_count) peak_count = image_count;
      @(negedge clock);
   endtask

   // Weighted command pick; the spare code shows up now and then.
   function automatic logic [CMD_W-1:0] pick_command(input int insert_pct,
                                                     input int remove_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) return CMD_INSERT;
      if (roll < insert_pct + remove_pct) return CMD_REMOVE;
      if (roll < 95) return CMD_LOOKUP;
      return CMD_SPARE;
   endfunction

   // Key drawn from a handful of hot buckets so that rows fill up and
   // collide; negative multiples land in their own hot rows.
   function automatic logic [KEY_W-1:0] hot_key();
      int hot_row;
      int multiple;
      hot_row  = $urandom_range(0, 5) * 17;
      multiple = $urandom_range(0, 15) - 8;
      return KEY_W'(hot_row + BUCKETS * multiple);
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Key extremes, every command, present/absent cases and one row overflow.
   task automatic test_directed();
      send_request(CMD_LOOKUP, 32'd0);            // lookup on empty set
      send_request(CMD_INSERT, 32'd0);
      send_request(CMD_INSERT, 32'd0);            // insert of a present key
      send_request(CMD_INSERT, 32'h7FFF_FFFF);
      send_request(CMD_INSERT, 32'h8000_0000);
      send_request(CMD_INSERT, 32'hFFFF_FFFF);
      send_request(CMD_SPARE,  32'hFFFF_FFFF);    // spare code hits like a lookup
      send_request(CMD_REMOVE, 32'd5);            // remove of an absent key
      send_request(CMD_REMOVE, 32'hFFFF_FFFF);
      send_request(CMD_LOOKUP, 32'hFFFF_FFFF);
      // fill row 7, then overflow it
      send_request(CMD_INSERT, 32'd7);
      send_request(CMD_INSERT, 32'd108);
      send_request(CMD_INSERT, 32'd209);
      send_request(CMD_INSERT, 32'd310);
      send_request(CMD_INSERT, 32'd411);          // refused, row full
      send_request(CMD_LOOKUP, 32'd411);
      send_request(CMD_REMOVE, 32'd108);          // free way 1
      send_request(CMD_INSERT, 32'd411);          // lands in the freed way
      send_request(CMD_LOOKUP, 32'd411);
      send_request(CMD_INSERT, 32'd209);          // present in a full row: not refused
      send_request(CMD_REMOVE, 32'h8000_0000);
      send_request(CMD_REMOVE, 32'h7FFF_FFFF);
      send_request(CMD_SPARE,  32'd12345);
      send_request(CMD_REMOVE, 32'd0);
   endtask

   // 420 consecutive keys cover every residue 4-5 times: all slots fill,
   // count peaks at SLOTS and the overflow keys are refused.
   task automatic test_fill_table();
      int i;
      for (i = 0; i < 420; i++) send_request(CMD_INSERT, KEY_W'(i - 210));
   endtask

   task automatic test_drain_table();
      int i;
      for (i = 0; i < 420; i++) begin
         if (i % 8 == 0) send_request(CMD_SPARE, KEY_W'(419 - i - 210));
         send_request(CMD_REMOVE, KEY_W'(419 - i - 210));
      end
   endtask

   // Receiver holds off for a long stretch while requests keep coming, so
   // the output register and the pipeline fill and req ready drops.
   task automatic test_response_backpressure();
      int i;
      sender_idling    = 1'b0;
      hold_off_request = HOLD_OFF_CYCLES;
      for (i = 0; i < 40; i++) send_request(pick_command(60, 20), hot_key());
      sender_idling = 1'b1;
   endtask

   // Well-formed traffic on colliding keys, with random idling switched off
   // now and then for stretches at full rate.
   task automatic test_clustered_traffic();
      int i;
      for (i = 0; i < 560; i++) begin
         if (i % 80 == 0) begin
            sender_idling   = ($urandom_range(0, 3) != 0);
            receiver_idling = ($urandom_range(0, 3) != 0);
         end
         send_request(pick_command(45, 30), hot_key());
      end
      sender_idling   = 1'b1;
      receiver_idling = 1'b1;
   endtask

   // Full 32-bit random keys for bit toggling; half the time a recent key
   // is reused so lookups and removes find something.
   task automatic test_wide_keys();
      logic [KEY_W-1:0] recent[$];
      logic [KEY_W-1:0] key;
      int               i;
      for (i = 0; i < 200; i++) begin
         if (recent.size() != 0 && $urandom_range(0, 1) != 0)
            key = recent[$urandom_range(0, recent.size() - 1)];
         else
            key = $urandom();
         recent.insert(recent.size(), key);
         if (recent.size() > 16) void'(recent.pop_front());
         send_request(pick_command(40, 30), key);
      end
   endtask

   // Final stretch: no idling on either side.
   task automatic test_full_rate();
      int i;
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      for (i = 0; i < 150; i++) begin
         if ($urandom_range(0, 3) == 0) send_request(pick_command(40, 30), $urandom());
         else send_request(pick_command(40, 30), hot_key());
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("MISMATCH %s: got %0d, expected %0d (response after request %0d)",
               what, got, want, request_count);
   endtask

   // Receiver ready: long hold-off on request from a test, otherwise random
   // stall bursts while idling is on.
   int hold_left;
   int stall_left;
   always @(negedge clock) begin
      if (hold_off_request > 0) begin
         hold_left        = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_left > 0) begin
         rsp_bus.ready = 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else if (receiver_idling && $urandom_range(0, 7) == 0) begin
         rsp_bus.ready = 1'b0;
         stall_left    = $urandom_range(0, 16);
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   // Response checker: each accepted response against the oldest prediction.
   set_outcome_type oldest;
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected response, element_count", rsp_bus.element_count, 0);
         end else begin
            oldest = pending_outcomes.pop_front();
            if (rsp_bus.was_present !== oldest.was_present)
               report_mismatch("was_present", rsp_bus.was_present, oldest.was_present);
            if (rsp_bus.bucket_full !== oldest.bucket_full)
               report_mismatch("bucket_full", rsp_bus.bucket_full, oldest.bucket_full);
            if (rsp_bus.element_count !== oldest.element_count)
               report_mismatch("element_count", rsp_bus.element_count,
                               oldest.element_count);
         end
      end
   end

   // Watchdog: ends the run if no request or response moves for too long.
   int quiet_cycles;
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TIMEOUT: nothing moved for %0d cycles, %0d responses outstanding",
               QUIET_LIMIT, pending_outcomes.size());
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.command  = CMD_LOOKUP;
      req_bus.key      = '0;
      rsp_bus.ready    = 1'b0;
      sender_idling    = 1'b1;
      receiver_idling  = 1'b1;
      hold_off_request = 0;
      hold_left        = 0;
      stall_left       = 0;
      error_count      = 0;
      request_count    = 0;
      refused_count    = 0;
      hit_count        = 0;
      peak_count       = 0;
      image_count      = 0;
      foreach (image_used[s]) image_used[s] = 1'b0;

      // synchronous reset, released at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // first request simply waits out the clearing pass via ready
      test_directed();
      test_fill_table();
      test_drain_table();
      test_response_backpressure();
      test_clustered_traffic();
      test_wide_keys();
      test_full_rate();

      req_bus.valid = 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0)
         report_mismatch("responses missing", pending_outcomes.size(), 0);

      $display("Run covered %0d requests (%0d hits, %0d refused inserts), peak count %0d.",
               request_count, hit_count, refused_count, peak_count);
      $display("Included a full fill and drain, a %0d-cycle response hold-off %s",
               HOLD_OFF_CYCLES, "and a full-rate tail.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/his_pkg.sv
rtl/his_channels.sv
rtl/his_bucket_mod.sv
rtl/hashed_integer_set_top.sv
dv/hashed_integer_set_top_tb.sv
